[rtl/sslc_pkg.sv]
// Shared constants and types for the self-synchronizing LFSR byte cipher.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`timescale 1ns / 1ps

package sslc_pkg;

  localparam int RegBits  = 128;
  localparam int CfgDataW = 64;
  localparam int CfgIdxW  = 3;
  localparam int ByteW    = 8;

  localparam logic [CfgIdxW-1:0] CfgTapLow   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgTapHigh  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSeedLow  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSeedHigh = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDecrypt  = 3'd4;

  typedef struct packed {
    logic [RegBits-1:0] tap;
    logic [RegBits-1:0] seed;
    logic               decrypt;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data_in;
    logic             start_req;
  } item_t;

endpackage

[rtl/sslc_stream_if.sv]
// Valid/ready channel interfaces for the cipher input and result streams.
// Depends on sslc_pkg for the byte width.
`timescale 1ns / 1ps

interface sslc_in_if;
  logic                      valid;
  logic                      ready;
  logic [sslc_pkg::ByteW-1:0] data_in;
  logic                      start_req;

  modport source (output valid, output data_in, output start_req, input ready);
  modport sink   (input valid, input data_in, input start_req, output ready);
endinterface

interface sslc_out_if;
  logic                      valid;
  logic                      ready;
  logic [sslc_pkg::ByteW-1:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

[rtl/self_sync_lfsr_byte_cipher_top.sv]
// Top level of the self-synchronizing LFSR byte cipher.
// Depends on sslc_pkg, sslc_stream_if, sslc_cfg_regs, sslc_in_stage, sslc_core.
//
// Usage:
//   in_i  : valid/ready input channel, one byte (data_in) plus start_req per
//           transaction. start_req reloads the 128-bit shift register from the
//           seed before the byte is processed; bit 0 is handled first.
//   out_o : valid/ready result channel, one data_out byte per input transaction,
//           in order.
//   cfg   : write-only port (cfg_we_i, cfg_idx_i, cfg_data_i); index 0/1 tap
//           mask low/high, 2/3 seed low/high, 4 decrypt mode. Write while idle.
// Path: the input transaction is captured in the input register, then the
//   core step writes the result register, which drives out_o.
// Throughput: one byte per cycle while out_o.ready stays high; set by the
//   shift register update, which takes all eight bit steps of a byte at once.
// Reset: all config registers, the shift register and both valid flags clear.
// Stall: when out_o.ready is low the result holds; the input register still
//   takes one more transaction if it is empty, after which in_i.ready drops.
`timescale 1ns / 1ps

module self_sync_lfsr_byte_cipher_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sslc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sslc_pkg::CfgDataW-1:0] cfg_data_i,
  sslc_in_if.sink                       in_i,
  sslc_out_if.source                    out_o
);

  sslc_pkg::cfg_t  cfg;
  sslc_pkg::item_t item;
  logic            item_vld;
  logic            core_rdy;

  sslc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sslc_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .vld_o  (item_vld),
    .item_o (item),
    .rdy_i  (core_rdy)
  );

  sslc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .vld_i  (item_vld),
    .item_i (item),
    .rdy_o  (core_rdy),
    .out_o  (out_o)
  );

endmodule

[rtl/sslc_cfg_regs.sv]
// Configuration register file: tap mask, seed and mode.
// Depends on sslc_pkg for register codes and the cfg_t bundle.
`timescale 1ns / 1ps

module sslc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sslc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sslc_pkg::CfgDataW-1:0] cfg_data_i,
  output sslc_pkg::cfg_t                cfg_o
);

  logic [sslc_pkg::CfgDataW-1:0] tap_lo_q, tap_hi_q, seed_lo_q, seed_hi_q;
  logic                          decrypt_q;
  logic [2*sslc_pkg::CfgDataW-1:0] tap_full, seed_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_lo_q  <= '0;
      tap_hi_q  <= '0;
      seed_lo_q <= '0;
      seed_hi_q <= '0;
      decrypt_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sslc_pkg::CfgTapLow:   tap_lo_q  <= cfg_data_i;
        sslc_pkg::CfgTapHigh:  tap_hi_q  <= cfg_data_i;
        sslc_pkg::CfgSeedLow:  seed_lo_q <= cfg_data_i;
        sslc_pkg::CfgSeedHigh: seed_hi_q <= cfg_data_i;
        sslc_pkg::CfgDecrypt:  decrypt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign tap_full  = {tap_hi_q, tap_lo_q};
  assign seed_full = {seed_hi_q, seed_lo_q};

  // the two halves exactly fill the register width, so no position is dropped
  assign cfg_o.tap     = tap_full[sslc_pkg::RegBits-1:0];
  assign cfg_o.seed    = seed_full[sslc_pkg::RegBits-1:0];
  assign cfg_o.decrypt = decrypt_q;

endmodule

[rtl/sslc_in_stage.sv]
// Input register stage: takes one transaction per cycle while in_i.ready is high.
// Depends on sslc_pkg and sslc_in_if.
`timescale 1ns / 1ps

module sslc_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  sslc_in_if.sink        in_i,
  output logic           vld_o,
  output sslc_pkg::item_t item_o,
  input  logic           rdy_i
);

  logic            vld_q, vld_d;
  sslc_pkg::item_t item_q, item_d;
  logic            take;

  assign in_i.ready = !vld_q || rdy_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    vld_d  = vld_q;
    item_d = item_q;
    if (take) begin
      vld_d            = 1'b1;
      item_d.data_in   = in_i.data_in;
      item_d.start_req = in_i.start_req;
    end else if (rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[rtl/sslc_core.sv]
// Cipher core: shift register state, eight bit steps per byte, result register.
// Depends on sslc_pkg and sslc_out_if.
`timescale 1ns / 1ps

module sslc_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sslc_pkg::cfg_t  cfg_i,
  input  logic            vld_i,
  input  sslc_pkg::item_t item_i,
  output logic            rdy_o,
  sslc_out_if.source      out_o
);

  logic [sslc_pkg::RegBits-1:0] sr_q, sr_d;
  logic [sslc_pkg::ByteW-1:0]   res_q, res_d;
  logic                         res_vld_q, res_vld_d;
  logic [sslc_pkg::RegBits-1:0] sr_w;
  logic [sslc_pkg::ByteW-1:0]   byte_w;
  logic                         fire;

  assign rdy_o = !res_vld_q || out_o.ready;
  assign fire  = vld_i && rdy_o;

  always_comb begin
    logic ks, bo, fb;
    sr_w   = item_i.start_req ? cfg_i.seed : sr_q;
    byte_w = '0;
    for (int i = 0; i < sslc_pkg::ByteW; i++) begin
      ks        = ^(sr_w & cfg_i.tap);
      bo        = item_i.data_in[i] ^ ks;
      fb        = cfg_i.decrypt ? item_i.data_in[i] : bo;
      byte_w[i] = bo;
      sr_w      = {sr_w[sslc_pkg::RegBits-2:0], fb};
    end
  end

  always_comb begin
    sr_d      = sr_q;
    res_d     = res_q;
    res_vld_d = res_vld_q;
    if (fire) begin
      sr_d      = sr_w;
      res_d     = byte_w;
      res_vld_d = 1'b1;
    end else if (out_o.ready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      sr_q      <= sr_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_o.valid    = res_vld_q;
  assign out_o.data_out = res_q;

endmodule

[rtl/sslc_checker.sv]
// Port-level checker for the cipher top level, attached by bind.
// Depends on sslc_pkg; watches only the top-level ports.
`timescale 1ns / 1ps

module sslc_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sslc_pkg::ByteW-1:0] out_data
);

  logic [1:0] cnt_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> cnt_q != 2'd0)
    else $error("result with no transaction in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 && (cnt_q != 2'd2 || !in_acc || out_acc))
    else $error("more transactions in flight than pipeline depth");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && cnt_q == 2'd0 |=> ##1 out_valid)
    else $error("result not valid two cycles after transaction");

endmodule

bind self_sync_lfsr_byte_cipher_top sslc_checker u_sslc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_data  (out_o.data_out)
);
